// ----- rtl/core/wsd_pkg.sv -----
package wsd_pkg;

  // Input transaction: one received byte and its end-of-buffer flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } byte_item_t;

  // Output transaction: one unmasked payload byte or a truncation error
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
    logic       status;
  } result_item_t;

  // Registered byte handed from the input stage to the parser
  typedef struct packed {
    logic       valid;
    byte_item_t item;
  } in_stage_t;

  // Parser result handed to the output stage
  typedef struct packed {
    logic         valid;
    result_item_t item;
  } parse_result_t;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_OPCODE = 6'b000001,
    PH_LENGTH = 6'b000010,
    PH_EXTLEN = 6'b000100,
    PH_KEY    = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_IGNORE = 6'b100000
  } phase_t;

  // Status codes
  localparam logic STATUS_DATA      = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  // Header constants
  localparam logic [3:0] OPCODE_TEXT = 4'h1;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

// ----- rtl/core/wsd_in_stage.sv -----
module wsd_in_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  wsd_pkg::byte_item_t    byte_item,
  input  logic                   consume,
  output wsd_pkg::in_stage_t     stage
);

  logic                valid;
  wsd_pkg::byte_item_t item;

  // Take a new transaction when empty or when the held one leaves this cycle
  assign byte_ready = !valid || consume;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      valid <= 1'b1;
    end else if (consume) begin
      valid <= 1'b0;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      item <= byte_item;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

// ----- rtl/core/wsd_parser.sv -----
module wsd_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  wsd_pkg::in_stage_t      stage,
  input  logic                    out_space,
  output logic                    consume,
  output wsd_pkg::parse_result_t  result
);

  wsd_pkg::phase_t phase, phase_next;
  logic [3:0]      header_count, header_count_next;
  logic [63:0]     frame_length, frame_length_next;
  logic [31:0]     mask_key, mask_key_next;
  logic            mask_on, mask_on_next;

  logic [7:0]  b;
  logic        eob;
  logic [63:0] length_shift;

  assign consume      = stage.valid && out_space;
  assign b            = stage.item.data_byte;
  assign eob          = stage.item.end_of_buffer;
  assign length_shift = {frame_length[55:0], b};

  // Decode one byte against the current phase
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    frame_length_next = frame_length;
    mask_key_next     = mask_key;
    mask_on_next      = mask_on;
    result            = '0;

    case (phase)
      wsd_pkg::PH_OPCODE: begin
        phase_next = (b[3:0] == wsd_pkg::OPCODE_TEXT) ? wsd_pkg::PH_LENGTH
                                                      : wsd_pkg::PH_IGNORE;
      end
      wsd_pkg::PH_LENGTH: begin
        mask_on_next = b[7];
        if (b[6:0] == wsd_pkg::LEN_EXT16) begin
          frame_length_next = '0;
          header_count_next = wsd_pkg::EXT16_BYTES;
          phase_next        = wsd_pkg::PH_EXTLEN;
        end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
          frame_length_next = '0;
          header_count_next = wsd_pkg::EXT64_BYTES;
          phase_next        = wsd_pkg::PH_EXTLEN;
        end else begin
          frame_length_next = {57'd0, b[6:0]};
          if (b[7]) begin
            header_count_next = wsd_pkg::KEY_BYTES;
            phase_next        = wsd_pkg::PH_KEY;
          end else begin
            phase_next = (b[6:0] == 7'd0) ? wsd_pkg::PH_IGNORE : wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        frame_length_next = length_shift;
        header_count_next = header_count - 4'd1;
        if (header_count == 4'd1) begin
          if (mask_on) begin
            header_count_next = wsd_pkg::KEY_BYTES;
            phase_next        = wsd_pkg::PH_KEY;
          end else begin
            phase_next = (length_shift == 64'd0) ? wsd_pkg::PH_IGNORE
                                                 : wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_KEY: begin
        mask_key_next     = {mask_key[23:0], b};
        header_count_next = header_count - 4'd1;
        if (header_count == 4'd1) begin
          phase_next = (frame_length == 64'd0) ? wsd_pkg::PH_IGNORE
                                               : wsd_pkg::PH_DATA;
        end
      end
      wsd_pkg::PH_DATA: begin
        // Unmask with the leading key byte, then rotate the key for the next byte
        result.valid             = 1'b1;
        result.item.payload_byte = b ^ (mask_on ? mask_key[31:24] : 8'd0);
        result.item.last_byte    = (frame_length == 64'd1);
        result.item.status       = wsd_pkg::STATUS_DATA;
        frame_length_next        = frame_length - 64'd1;
        mask_key_next            = {mask_key[23:0], mask_key[31:24]};
        if (frame_length == 64'd1) begin
          phase_next = wsd_pkg::PH_IGNORE;
        end
      end
      default: begin
      end
    endcase

    // Buffer end: flag an unfinished text frame, then return to reset state
    if (eob) begin
      if (phase_next inside {wsd_pkg::PH_LENGTH, wsd_pkg::PH_EXTLEN,
                             wsd_pkg::PH_KEY, wsd_pkg::PH_DATA}) begin
        result.valid             = 1'b1;
        result.item.payload_byte = 8'd0;
        result.item.last_byte    = 1'b0;
        result.item.status       = wsd_pkg::STATUS_TRUNCATED;
      end
      phase_next        = wsd_pkg::PH_OPCODE;
      header_count_next = '0;
      frame_length_next = '0;
      mask_key_next     = '0;
      mask_on_next      = 1'b0;
    end

    if (!consume) begin
      result.valid = 1'b0;
    end
  end

  // Advance parser state once per consumed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= wsd_pkg::PH_OPCODE;
      header_count <= '0;
      frame_length <= '0;
      mask_key     <= '0;
      mask_on      <= 1'b0;
    end else if (consume) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      frame_length <= frame_length_next;
      mask_key     <= mask_key_next;
      mask_on      <= mask_on_next;
    end
  end

  // An error result only comes from a byte that ends the buffer
  assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.item.status == wsd_pkg::STATUS_TRUNCATED) |-> eob)
    else $error("truncation result without end of buffer");

  // A buffer end always returns the parser to the first header byte
  assert property (@(posedge clk) disable iff (rst)
    consume && eob |=> phase == wsd_pkg::PH_OPCODE)
    else $error("parser not back at header start after buffer end");

  // The final payload byte closes the frame
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.item.last_byte |=>
      (phase == wsd_pkg::PH_IGNORE) || (phase == wsd_pkg::PH_OPCODE))
    else $error("payload continues after last byte");

  // Payload bytes only come out of the data phase
  assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.item.status == wsd_pkg::STATUS_DATA) |->
      phase == wsd_pkg::PH_DATA)
    else $error("payload byte outside data phase");

endmodule

// ----- rtl/core/wsd_out_stage.sv -----
module wsd_out_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  wsd_pkg::parse_result_t  result,
  output logic                    out_space,
  output logic                    result_valid,
  input  logic                    result_ready,
  output wsd_pkg::result_item_t   result_item
);

  logic                  valid;
  wsd_pkg::result_item_t item;

  // Room for a new result when empty or when the held one is taken now
  assign out_space = !valid || result_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_space) begin
      valid <= result.valid;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (out_space && result.valid) begin
      item <= result.item;
    end
  end

  assign result_valid = valid;
  assign result_item  = item;

endmodule

// ----- rtl/core/websocket_frame_deframer_unit.sv -----
// A byte accepted into the input register is parsed combinationally and written into the
// result register, which presents the result until result_ready takes it.
// Throughput: one byte per cycle unless a result waits on result_ready; all bytes then stall.
// Reset: synchronous, active high; empties both registers and returns the parser
// to the first header byte of a new frame.
module websocket_frame_deframer_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  wsd_pkg::byte_item_t    byte_item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output wsd_pkg::result_item_t  result_item
);

  wsd_pkg::in_stage_t     stage;
  wsd_pkg::parse_result_t result;
  logic                   consume;
  logic                   out_space;

  wsd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .consume    (consume),
    .stage      (stage)
  );

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .out_space (out_space),
    .consume   (consume),
    .result    (result)
  );

  wsd_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .result       (result),
    .out_space    (out_space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
